// ----- src/tsfp_pkg.sv -----
`timescale 1ns / 1ps
package tsfp_pkg;
	localparam int VERTEX_COUNT = 256;
	localparam int STACK_DEPTH = 16;
	localparam int VW = $clog2(VERTEX_COUNT);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int TW = 22;
	localparam int AW = 23;
	localparam int DW = 24;
	localparam int TRIPLE_W = TW + AW + DW;
	localparam int BEST_W = 2 * DW;
	localparam logic [DW-1:0] UNREACHED = 24'd9999999;
	localparam logic [DW-1:0] DIST_LIMIT = 24'd9999998;

	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_SOURCE = 2'd0;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_CLEAR,
		ST_IDLE,
		ST_RDBEST,
		ST_LVL_V,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_TOP_RD,
		ST_TOP_CHK,
		ST_BEST_CHK,
		ST_OUT
	} state_t;
endpackage

// ----- src/tsfp_ram.sv -----
`timescale 1ns / 1ps
module tsfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/temporal_shortest_fastest_path_unit.sv -----
`timescale 1ns / 1ps
// Temporal shortest-fastest path unit. Takes one command item at a time (edge, vertex read,
// clear, unused) and returns exactly one result item for each; it is not ready for the next
// item until that result is taken. Edges must arrive sorted by arrival time, then by tail.
// An edge reads its tail and head stack levels, then scans the tail stack top-down through one
// triple RAM read port, reading and then checking one triple at a time; an edge from the source
// vertex skips the scan. A read answers after one best-table read, an unused command without.
// Reset and each clear sweep the per-vertex tables one vertex per cycle; the clear's result
// follows its sweep. Configuration writes are taken at any time, and a sweep zeroes the source
// vertex that was set when it started.
module temporal_shortest_fastest_path_unit (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [7:0] from_vertex,
	input logic [7:0] to_vertex,
	input logic [21:0] departure_time,
	input logic [21:0] duration,
	input logic [7:0] query_vertex,
	output logic out_valid,
	input logic out_ready,
	output logic [23:0] best_span,
	output logic [23:0] best_dist,
	output logic accepted,
	output logic overflow
);
	import tsfp_pkg::*;

	state_t state_q, state_d;
	logic [7:0] src_q, sweep_src_q;
	logic [VW:0] clr_q;
	logic [1:0] cmd_q;
	logic [7:0] u_q, v_q;
	logic [TW-1:0] dep_q;
	logic [TW-1:0] dur_q;
	logic [SW:0] k_q;
	logic [LW-1:0] lvl_v_q;
	logic [TW-1:0] nt_start_q;
	logic [AW-1:0] nt_arr_q;
	logic [DW-1:0] nt_dist_q;
	logic [DW-1:0] bj_q, bt_q;
	logic acc_q, ovf_q, replace_q;
	logic [DW-1:0] jt_q, tt_q;
	logic out_valid_q;

	logic sweep, commit;
	logic [DW-1:0] bj_n, bt_n;

	// memories
	logic t_we;
	logic [VW+SW-1:0] t_waddr, t_raddr;
	logic [TRIPLE_W-1:0] t_wdata, t_rdata;
	logic b_we;
	logic [VW-1:0] b_waddr, b_raddr;
	logic [BEST_W-1:0] b_wdata, b_rdata;
	logic l_we;
	logic [VW-1:0] l_waddr, l_raddr;
	logic [LW-1:0] l_wdata, l_rdata;

	tsfp_ram #(.WIDTH(TRIPLE_W), .DEPTH(VERTEX_COUNT * STACK_DEPTH)) u_triple (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);
	tsfp_ram #(.WIDTH(BEST_W), .DEPTH(VERTEX_COUNT)) u_best (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);
	tsfp_ram #(.WIDTH(LW), .DEPTH(VERTEX_COUNT)) u_level (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	logic [TW-1:0] r_start;
	logic [AW-1:0] r_arr;
	logic [DW-1:0] r_dist;
	assign r_start = t_rdata[TRIPLE_W-1 -: TW];
	assign r_arr = t_rdata[DW +: AW];
	assign r_dist = t_rdata[DW-1:0];

	logic in_fire, out_fire, u_ok, v_ok, is_src;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign u_ok = ({24'd0, u_q} < 32'(VERTEX_COUNT));
	assign v_ok = ({24'd0, v_q} < 32'(VERTEX_COUNT));
	assign is_src = (u_q == src_q);

	// extended candidate distance and arrival
	logic [AW-1:0] new_arr;
	logic [DW:0] dsum;
	logic [DW-1:0] new_dist;
	assign new_arr = {1'b0, dep_q} + {1'b0, dur_q};
	assign dsum = {1'b0, r_dist} + {3'b0, dur_q};
	assign new_dist = (dsum > {1'b0, DIST_LIMIT}) ? DIST_LIMIT : dsum[DW-1:0];

	// dominance of stored top (r_*) versus candidate nt_*
	logic top_wins, new_wins;
	always_comb begin
		if (r_start == nt_start_q) begin
			top_wins = (r_arr <= nt_arr_q) && (r_dist <= nt_dist_q);
			new_wins = (nt_arr_q <= r_arr) && (nt_dist_q <= r_dist);
		end else if (r_arr == nt_arr_q) begin
			top_wins = nt_start_q < r_start;
			new_wins = r_start < nt_start_q;
		end else begin
			top_wins = (nt_start_q < r_start) && ({1'b0, nt_arr_q} > {2'b0, r_start});
			new_wins = (r_start < nt_start_q) && ({1'b0, r_arr} > {2'b0, nt_start_q});
		end
	end

	logic [DW-1:0] span;
	assign span = {1'b0, nt_arr_q} - {2'b0, nt_start_q};
	logic full_v;
	assign full_v = (lvl_v_q >= LW'(STACK_DEPTH));

	assign sweep = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign commit = (state_q == ST_BEST_CHK) && !(full_v && !replace_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (clr_q == (VW+1)'(VERTEX_COUNT - 1)) state_d = ST_IDLE;
			ST_CLEAR: if (clr_q == (VW+1)'(VERTEX_COUNT - 1)) state_d = ST_OUT;
			ST_IDLE: if (in_fire) begin
				case (command)
					CMD_EDGE, CMD_READ: state_d = ST_RDBEST;
					CMD_CLEAR: state_d = ST_CLEAR;
					default: state_d = ST_OUT;
				endcase
			end
			ST_RDBEST: begin
				if (cmd_q != CMD_EDGE || !u_ok || !v_ok) state_d = ST_OUT;
				else state_d = ST_LVL_V;
			end
			ST_LVL_V: begin
				if (is_src) state_d = ST_BEST_CHK;
				else state_d = (k_q == '0) ? ST_OUT : ST_SCAN_RD;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if ({1'b0, r_arr} <= {2'b0, dep_q})
					state_d = (lvl_v_q == '0) ? ST_BEST_CHK : ST_TOP_RD;
				else state_d = (k_q == '0) ? ST_OUT : ST_SCAN_RD;
			end
			ST_TOP_RD: state_d = ST_TOP_CHK;
			ST_TOP_CHK: state_d = (top_wins && !new_wins) ? ST_OUT : ST_BEST_CHK;
			ST_BEST_CHK: state_d = ST_OUT;
			ST_OUT: if (out_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = (state_q == ST_IDLE) && !out_valid_q;
		t_we = commit;
		t_waddr = replace_q ? {v_q, lvl_v_q[SW-1:0] - SW'(1)} : {v_q, lvl_v_q[SW-1:0]};
		t_wdata = {nt_start_q, nt_arr_q, nt_dist_q};
		t_raddr = (state_q == ST_TOP_RD) ? {v_q, lvl_v_q[SW-1:0] - SW'(1)}
			: {u_q, k_q[SW-1:0] - SW'(1)};
		b_we = sweep || commit;
		b_waddr = sweep ? clr_q[VW-1:0] : v_q;
		if (sweep) b_wdata = (clr_q[VW-1:0] == sweep_src_q) ? '0 : {UNREACHED, UNREACHED};
		else b_wdata = {bj_n, bt_n};
		b_raddr = (state_q == ST_IDLE && command == CMD_READ) ? query_vertex : to_vertex;
		l_we = sweep || (commit && !replace_q);
		l_waddr = sweep ? clr_q[VW-1:0] : v_q;
		l_wdata = sweep ? '0 : lvl_v_q + LW'(1);
		l_raddr = (state_q == ST_IDLE) ? from_vertex : v_q;
	end

	// improve rule
	always_comb begin
		bj_n = bj_q;
		bt_n = bt_q;
		if (is_src) begin
			bj_n = {2'b0, dur_q};
			bt_n = {2'b0, dur_q};
		end else if (span < bj_q) begin
			bj_n = span;
			bt_n = nt_dist_q;
		end else if (span == bj_q && nt_dist_q < bt_q) begin
			bt_n = nt_dist_q;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			src_q <= '0;
			sweep_src_q <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready && paddr == REG_SOURCE)
				src_q <= pwdata[7:0];
			// hold the source that a clear sweep zeroes
			if (in_fire && command == CMD_CLEAR) sweep_src_q <= src_q;
			if (sweep) clr_q <= clr_q + (VW+1)'(1);
			else clr_q <= '0;
			if (state_q != ST_OUT && state_d == ST_OUT) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				cmd_q <= command;
				u_q <= from_vertex;
				v_q <= to_vertex;
				dep_q <= departure_time;
				dur_q <= duration;
				acc_q <= 1'b0;
				ovf_q <= 1'b0;
				replace_q <= 1'b0;
				jt_q <= '0;
				tt_q <= '0;
			end
			ST_RDBEST: begin
				k_q <= (SW+1)'(l_rdata);
				bj_q <= b_rdata[BEST_W-1 -: DW];
				bt_q <= b_rdata[DW-1:0];
				jt_q <= b_rdata[BEST_W-1 -: DW];
				tt_q <= b_rdata[DW-1:0];
				if (cmd_q == CMD_EDGE && (!u_ok || !v_ok)) begin
					jt_q <= UNREACHED;
					tt_q <= UNREACHED;
				end
				nt_start_q <= dep_q;
				nt_arr_q <= new_arr;
				nt_dist_q <= {2'b0, dur_q};
			end
			ST_LVL_V: lvl_v_q <= l_rdata;
			ST_SCAN_RD: k_q <= k_q - (SW+1)'(1);
			ST_SCAN_CHK: begin
				nt_start_q <= r_start;
				nt_arr_q <= new_arr;
				nt_dist_q <= new_dist;
			end
			ST_TOP_CHK: replace_q <= new_wins;
			ST_BEST_CHK: begin
				if (full_v && !replace_q) ovf_q <= 1'b1;
				else begin
					acc_q <= 1'b1;
					bj_q <= bj_n;
					bt_q <= bt_n;
					jt_q <= bj_n;
					tt_q <= bt_n;
				end
			end
			default: begin
			end
		endcase
	end

	assign pready = 1'b1;
	assign prdata = {24'd0, src_q};
	assign out_valid = out_valid_q;
	assign best_span = jt_q;
	assign best_dist = tt_q;
	assign accepted = acc_q;
	assign overflow = ovf_q;
endmodule
